// ===== src/shift_fifo_with_search_defines.svh =====
// assertion helpers shared by the rtl
`ifndef SHIFT_FIFO_WITH_SEARCH_DEFINES_SVH
`define SHIFT_FIFO_WITH_SEARCH_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SFWS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SFWS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sfws_pkg.sv =====
`default_nettype none

package sfws_pkg;

	localparam int SFWS_DEPTH = 16;
	localparam int SFWS_WIDTH = 32;

	// field widths on the ports
	localparam int KIND_W = 2;
	localparam int VAL_W = 32;
	localparam int IDX_W = 4;
	localparam int POS_W = 4;
	localparam int OCC_W = 5;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH   = 2'd0,
		KIND_POP    = 2'd1,
		KIND_READ   = 2'd2,
		KIND_SEARCH = 2'd3
	} sfws_kind_t;

	// per-cell control from the queue controller
	typedef struct packed {
		logic load;
		logic shift;
		logic capture;
		logic occupied;
	} sfws_cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/sfws_cell.sv =====
`default_nettype none

module sfws_cell import sfws_pkg::*; #(
	parameter int WIDTH = SFWS_WIDTH
) (
	input  wire logic             clk,
	input  wire sfws_cell_ctl_t   ctl,
	input  wire logic [WIDTH-1:0] push_value,
	input  wire logic [WIDTH-1:0] next_value,
	input  wire logic [WIDTH-1:0] key,
	output logic      [WIDTH-1:0] value,
	output logic                  match_s1
);

	logic [WIDTH-1:0] value_q;

	// load from the tail side, or take the neighbour's entry on a pop
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			value_q <= push_value;
		end else if (ctl.shift) begin
			value_q <= next_value;
		end
	end

	// compare against the contents before this transfer's update
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			match_s1 <= ctl.occupied && (value_q == key);
		end
	end

	assign value = value_q;

endmodule

`default_nettype wire

// ===== src/sfws_find_first.sv =====
`default_nettype none

module sfws_find_first import sfws_pkg::*; #(
	parameter int N = SFWS_DEPTH,
	localparam int IW = (N > 1) ? $clog2(N) : 1
) (
	input  wire logic [N-1:0]  req,
	output logic               found,
	output logic [IW-1:0]      first
);

	// lowest set bit wins
	always_comb begin
		found = 1'b0;
		first = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (req[i]) begin
				found = 1'b1;
				first = IW'(i);
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/shift_fifo_with_search.sv =====
// bounded fifo held in a row of shifting cells, with read-at-index and search
// slave channel (s_*): one operation per transfer, kind in s_tuser,
//   value and index in s_tdata
// master channel (m_*): exactly one result per operation, in order
// push appends at the tail (dropped when full), pop returns the head and
//   every cell but the last takes its neighbour's entry, read returns the entry at index,
//   search returns the lowest matching position
// pipeline: two register stages; an operation's outcome and match bits are registered
//   in the middle stage, then packed into the result register
// throughput: one operation per cycle while the result is not stalled; the cells shift
//   and all compare in parallel, the match vector is priority-encoded in a second stage
// stalls: while m_tready is low the result register holds, the middle stage
//   still accepts one more operation, then s_tready drops
// reset: arst_n clears the fill count and both valid flags; the queue starts
//   empty and cell contents are left as they are (never read before written)

`default_nettype none

`include "shift_fifo_with_search_defines.svh"

module shift_fifo_with_search import sfws_pkg::*; #(
	parameter int DEPTH = SFWS_DEPTH,
	parameter int WIDTH = SFWS_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,  // value[31:0], index[35:32], zero pad
	input  wire logic [KIND_W-1:0]     s_tuser,  // kind[1:0]
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_TDATA_W-1:0]       m_tdata   // data[31:0], accepted, hit,
	                                             // position[37:34], occupancy[42:38],
	                                             // is_full, is_empty, zero pad
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// input unpacking
	logic                accept;
	sfws_kind_t          kind;
	logic [VAL_W-1:0]    in_value;
	logic [IDX_W-1:0]    in_index;
	logic [WIDTH+VAL_W-1:0] key_ext;
	logic [WIDTH-1:0]    key;

	assign accept   = s_tvalid && s_tready;
	assign kind     = sfws_kind_t'(s_tuser);
	assign in_value = s_tdata[VAL_W-1:0];
	assign in_index = s_tdata[VAL_W+IDX_W-1:VAL_W];
	// entries keep the low WIDTH bits of value
	assign key_ext  = {{WIDTH{1'b0}}, in_value};
	assign key      = key_ext[WIDTH-1:0];

	// fill count and the controller's view of the operation
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_next;
	logic             push_ok;
	logic             pop_ok;
	logic             read_ok;
	logic             op_accepted;
	logic [WIDTH-1:0] op_data;
	logic [WIDTH-1:0] rd_value;

	assign push_ok = (count_q != CW'(DEPTH));
	assign pop_ok  = (count_q != '0);
	// count never exceeds DEPTH, so this also keeps index inside the row
	assign read_ok = (int'(in_index) < int'(count_q));

	// the row of cells
	logic [WIDTH-1:0] cell_value [DEPTH];
	logic [DEPTH-1:0] match_s1;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		sfws_cell_ctl_t   ctl;
		logic [WIDTH-1:0] next_value;

		// last cell has no neighbour: it keeps its own entry on a pop
		if (g == DEPTH - 1) begin : g_last
			assign next_value = cell_value[g];
		end else begin : g_mid
			assign next_value = cell_value[g+1];
		end

		assign ctl.load     = accept && (kind == KIND_PUSH) && push_ok &&
		                      (count_q == CW'(g));
		assign ctl.shift    = accept && (kind == KIND_POP) && pop_ok;
		assign ctl.capture  = accept;
		assign ctl.occupied = (CW'(g) < count_q);

		sfws_cell #(
			.WIDTH(WIDTH)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.push_value (key),
			.next_value (next_value),
			.key        (key),
			.value      (cell_value[g]),
			.match_s1   (match_s1[g])
		);
	end

	// read port: only the first positions an index can name
	always_comb begin
		rd_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if ((i < (1 << IDX_W)) && (int'(in_index) == i)) begin
				rd_value = cell_value[i];
			end
		end
	end

	always_comb begin
		op_accepted = 1'b0;
		op_data     = '0;
		count_next  = count_q;
		unique case (kind)
			KIND_PUSH: begin
				if (push_ok) begin
					op_accepted = 1'b1;
					count_next  = count_q + CW'(1);
				end
			end
			KIND_POP: begin
				if (pop_ok) begin
					op_accepted = 1'b1;
					op_data     = cell_value[0];
					count_next  = count_q - CW'(1);
				end
			end
			KIND_READ: begin
				if (read_ok) begin
					op_accepted = 1'b1;
					op_data     = rd_value;
				end
			end
			KIND_SEARCH: begin
				// state untouched; match bits are captured in the cells
			end
		endcase
	end

	// data returned on the 32-bit field
	logic [WIDTH+VAL_W-1:0] data_ext;
	assign data_ext = {{VAL_W{1'b0}}, op_data};

	// middle stage: operation outcome, match vector sits in the cells
	logic             valid_s1;
	sfws_kind_t       kind_s1;
	logic             accepted_s1;
	logic [VAL_W-1:0] data_s1;
	logic [CW-1:0]    count_s1;
	logic             advance;

	logic             m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	assign advance  = !m_tvalid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			valid_s1   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				m_tvalid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1     <= kind;
			accepted_s1 <= op_accepted;
			data_s1     <= data_ext[VAL_W-1:0];
			count_s1    <= count_next;
		end
	end

	// second stage: lowest matching position, flags, packing
	logic                 found;
	logic [IW-1:0]        first;
	logic                 hit;
	logic [IW+POS_W-1:0]  pos_ext;
	logic [POS_W-1:0]     position;
	logic [CW+OCC_W-1:0]  occ_ext;
	logic                 is_full;
	logic                 is_empty;

	sfws_find_first #(
		.N(DEPTH)
	) u_find_first (
		.req   (match_s1),
		.found (found),
		.first (first)
	);

	assign hit      = (kind_s1 == KIND_SEARCH) && found;
	assign pos_ext  = {{POS_W{1'b0}}, first};
	assign position = hit ? pos_ext[POS_W-1:0] : '0;
	assign occ_ext  = {{OCC_W{1'b0}}, count_s1};
	assign is_full  = (count_s1 == CW'(DEPTH));
	assign is_empty = (count_s1 == '0);

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			m_tdata_q <= {3'b000, is_empty, is_full, occ_ext[OCC_W-1:0], position,
			              hit, accepted_s1, data_s1};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// checks
	`SFWS_ASSERT_IMPL(a_count_bound, 1'b1, int'(count_q) <= DEPTH,
		"fill count above depth")
	`SFWS_ASSERT_NEXT(a_push_grows, accept && (kind == KIND_PUSH) && push_ok,
		count_q == $past(count_q) + CW'(1), "accepted push did not grow the queue")
	`SFWS_ASSERT_NEXT(a_pop_shrinks, accept && (kind == KIND_POP) && pop_ok,
		count_q == $past(count_q) - CW'(1), "accepted pop did not shrink the queue")
	`SFWS_ASSERT_IMPL(a_hit_not_accepted, m_tvalid_q && m_tdata_q[VAL_W+1],
		!m_tdata_q[VAL_W], "search result flagged as accepted")
	`SFWS_ASSERT_IMPL(a_full_empty_excl, m_tvalid_q,
		!(m_tdata_q[VAL_W+2+POS_W+OCC_W] && m_tdata_q[VAL_W+3+POS_W+OCC_W]),
		"result both full and empty")

endmodule

`default_nettype wire

// ===== bench/shift_fifo_with_search_test.sv =====
module shift_fifo_with_search_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sfws_pkg::*;

	localparam int QDEPTH = SFWS_DEPTH;
	// stimulus items left in the queue once the calm tail begins
	localparam int CALM_TAIL = 40;

	// one operation as the sender sees it
	typedef struct packed {
		sfws_kind_t           kind;
		logic [VAL_W-1:0]     value;
		logic [IDX_W-1:0]     index;
		logic                 drain_first;  // hold off until every result is back
	} fifo_op_t;

	// one result, with the fields that m_tdata carries
	typedef struct packed {
		logic [VAL_W-1:0]     data;
		logic                 accepted;
		logic                 hit;
		logic [POS_W-1:0]     position;
		logic [OCC_W-1:0]     occupancy;
		logic                 is_full;
		logic                 is_empty;
	} fifo_result_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata = '0;
	logic [KIND_W-1:0]      s_tuser = KIND_PUSH;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;

	fifo_op_t               pending_ops[$];
	fifo_result_t           awaited_results[$];
	logic [VAL_W-1:0]       recent_values[$];
	fifo_op_t               op_on_bus;
	int                     mismatches = 0;
	int                     result_no = 0;
	int                     send_gap = 0;
	int                     recv_stall = 0;

	// shadow of the queue contents
	logic [VAL_W-1:0]       shadow_cells[QDEPTH];
	int                     shadow_fill = 0;

	shift_fifo_with_search dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// carries out one operation on the shadow queue and returns its result
	function automatic fifo_result_t fifo_apply(input fifo_op_t op);
		fifo_result_t r;
		logic         found;
		r = '0;
		found = 1'b0;
		case (op.kind)
			KIND_PUSH: begin
				if (shadow_fill < QDEPTH) begin
					shadow_cells[shadow_fill] = op.value;
					shadow_fill++;
					r.accepted = 1'b1;
				end
			end
			KIND_POP: begin
				if (shadow_fill > 0) begin
					r.data = shadow_cells[0];
					for (int i = 0; i < QDEPTH - 1; i++)
						shadow_cells[i] = shadow_cells[i + 1];
					shadow_fill--;
					r.accepted = 1'b1;
				end
			end
			KIND_READ: begin
				if (int'(op.index) < shadow_fill) begin
					r.data = shadow_cells[op.index];
					r.accepted = 1'b1;
				end
			end
			default: begin
				// lowest matching position wins
				for (int i = 0; i < shadow_fill; i++) begin
					if (!found && shadow_cells[i] == op.value) begin
						found = 1'b1;
						r.hit = 1'b1;
						r.position = POS_W'(i);
					end
				end
			end
		endcase
		r.occupancy = OCC_W'(shadow_fill);
		r.is_full = (shadow_fill == QDEPTH);
		r.is_empty = (shadow_fill == 0);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got_v,
			input logic [31:0] want_v);
		$display("mismatch on result %0d, %s: got %0h, want %0h", result_no, what, got_v,
			want_v);
		mismatches++;
	endtask

	task automatic add_op(input sfws_kind_t kind, input logic [VAL_W-1:0] value,
			input logic [IDX_W-1:0] index, input logic drain_first);
		fifo_op_t op;
		op.kind = kind;
		op.value = value;
		op.index = index;
		op.drain_first = drain_first;
		pending_ops.push_back(op);
		if (kind == KIND_PUSH) begin
			recent_values.push_back(value);
			if (recent_values.size() > QDEPTH)
				void'(recent_values.pop_front());
		end
	endtask

	// mostly full-range values, with a small pool for duplicates and the extremes
	function automatic logic [VAL_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 25)
			return VAL_W'($urandom_range(0, 3));
		else if (roll < 35)
			return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
		else
			return $urandom;
	endfunction

	// search values mostly taken from what was pushed lately, so hits are common
	function automatic logic [VAL_W-1:0] pick_search_value();
		if (recent_values.size() != 0 && $urandom_range(0, 99) < 65)
			return recent_values[$urandom_range(0, recent_values.size() - 1)];
		return pick_value();
	endfunction

	// sender: presents the next queued operation and predicts on every transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				awaited_results.push_back(fifo_apply(op_on_bus));
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_ops.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (pending_ops[0].drain_first && awaited_results.size() != 0) begin
					// let the block drain completely before this one goes out
					s_tvalid <= 1'b0;
				end else if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(1, 15) - 1;
					s_tvalid <= 1'b0;
				end else begin
					op_on_bus = pending_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {{(S_TDATA_W - VAL_W - IDX_W){1'b0}}, op_on_bus.index,
						op_on_bus.value};
					s_tuser <= op_on_bus.kind;
				end
			end
		end
	end

	// receiver back-pressure in random bursts, none in the calm tail
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			m_tready <= 1'b0;
		end else if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
			recv_stall = $urandom_range(1, 15) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor: every result transfer is checked against the oldest prediction
	always @(posedge clk) begin : check_results
		fifo_result_t got;
		fifo_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.data = m_tdata[31:0];
			got.accepted = m_tdata[32];
			got.hit = m_tdata[33];
			got.position = m_tdata[37:34];
			got.occupancy = m_tdata[42:38];
			got.is_full = m_tdata[43];
			got.is_empty = m_tdata[44];
			if (awaited_results.size() == 0) begin
				report_mismatch("result with no operation outstanding", m_tdata[31:0], 0);
			end else begin
				want = awaited_results.pop_front();
				if (got.data !== want.data)
					report_mismatch("data", got.data, want.data);
				if (got.accepted !== want.accepted)
					report_mismatch("accepted", got.accepted, want.accepted);
				if (got.hit !== want.hit)
					report_mismatch("hit", got.hit, want.hit);
				if (got.position !== want.position)
					report_mismatch("position", got.position, want.position);
				if (got.occupancy !== want.occupancy)
					report_mismatch("occupancy", got.occupancy, want.occupancy);
				if (got.is_full !== want.is_full)
					report_mismatch("is_full", got.is_full, want.is_full);
				if (got.is_empty !== want.is_empty)
					report_mismatch("is_empty", got.is_empty, want.is_empty);
			end
			result_no++;
		end
	end

	// stimulus and end of run
	initial begin
		int roll;
		int mode;
		logic [VAL_W-1:0] v;

		// directed: empty-queue cases, field extremes, duplicates, out-of-range reads
		add_op(KIND_POP, 32'h0, 4'd0, 1'b0);
		add_op(KIND_READ, 32'h0, 4'd0, 1'b0);
		add_op(KIND_SEARCH, 32'h0, 4'd0, 1'b0);
		add_op(KIND_PUSH, 32'h8000_0000, 4'd15, 1'b0);
		add_op(KIND_PUSH, 32'h7fff_ffff, 4'd0, 1'b0);
		add_op(KIND_PUSH, 32'h0000_0000, 4'd0, 1'b0);
		add_op(KIND_PUSH, 32'hffff_ffff, 4'd0, 1'b0);
		add_op(KIND_PUSH, 32'h7fff_ffff, 4'd0, 1'b0);
		add_op(KIND_SEARCH, 32'h7fff_ffff, 4'd15, 1'b0);
		add_op(KIND_SEARCH, 32'hffff_ffff, 4'd0, 1'b0);
		add_op(KIND_SEARCH, 32'h0001_2345, 4'd0, 1'b0);
		add_op(KIND_READ, 32'hffff_ffff, 4'd4, 1'b0);
		add_op(KIND_READ, 32'h0, 4'd5, 1'b0);
		add_op(KIND_READ, 32'h0, 4'd15, 1'b0);
		add_op(KIND_POP, 32'hffff_ffff, 4'd15, 1'b0);
		add_op(KIND_READ, 32'h0, 4'd0, 1'b0);

		// fill to the brim with random content, then push when full,
		// read the last cell and search for the newest entry
		for (int i = 0; i < 12; i++)
			add_op(KIND_PUSH, pick_value(), 4'($urandom), 1'b0);
		add_op(KIND_PUSH, pick_value(), 4'($urandom), 1'b0);
		add_op(KIND_READ, 32'($urandom), 4'd15, 1'b0);
		add_op(KIND_SEARCH, recent_values[recent_values.size() - 2], 4'($urandom), 1'b0);

		// random phases alternating filling, mixed traffic and draining
		for (int n = 0; n < 450; n++) begin
			mode = (n / 40) % 3;
			roll = $urandom_range(0, 99);
			if (mode == 0)
				roll = (roll < 70) ? 0 : (roll < 80) ? 1 : (roll < 90) ? 2 : 3;
			else if (mode == 1)
				roll = (roll < 30) ? 0 : (roll < 55) ? 1 : (roll < 75) ? 2 : 3;
			else
				roll = (roll < 10) ? 0 : (roll < 70) ? 1 : (roll < 85) ? 2 : 3;
			v = (roll == 3) ? pick_search_value() : pick_value();
			// one operation waits for the block to run dry
			add_op(sfws_kind_t'(roll), v, 4'($urandom_range(0, 15)), n == 200);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || s_tvalid)
			@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		// keep clocking so a stray result would be caught
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== shift_fifo_with_search.f =====
+incdir+src
src/sfws_pkg.sv
src/sfws_cell.sv
src/sfws_find_first.sv
src/shift_fifo_with_search.sv
bench/shift_fifo_with_search_test.sv
